>>> design/ihc_pkg.sv
// Shared types and constants of the impact hit counter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ihc_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int TIME_W   = 32;
  localparam int SCORE_W  = 10;
  localparam int TEMPO_W  = 22;
  localparam int LOCK_W   = 13;
  localparam int GAP_W    = 14;
  localparam int CFG_W    = 14;

  // Register reset values
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 12'd1200;
  localparam logic [LOCK_W-1:0]   LOCKOUT_RST   = 13'd120;
  localparam logic [GAP_W-1:0]    GAP_RST       = 14'd600;

  // Scoring and tempo constants
  localparam int FULL_SCALE      = 4095;
  localparam int SCORE_MAX       = 999;
  localparam int HPM_SCALE       = 60000;
  localparam int TEMPO_LIMIT     = 4194303;
  localparam int TEMPO_WINDOW_MS = 10000;
  localparam int HISTORY_DEPTH   = 64;

  // Derived widths
  localparam int HIST_AW = $clog2(HISTORY_DEPTH);
  localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int WIN_W   = $clog2(TEMPO_WINDOW_MS + 1);
  localparam int DIV_W   = (WIN_W > SAMPLE_W) ? WIN_W : SAMPLE_W;
  localparam int TPROD_W = $clog2(HISTORY_DEPTH * HPM_SCALE + 1);
  localparam int SPROD_W = $clog2(FULL_SCALE * SCORE_MAX + 1);
  localparam int DVD_MIN = (SPROD_W > TEMPO_W) ? SPROD_W : TEMPO_W;
  localparam int DVD_W   = (TPROD_W > DVD_MIN) ? TPROD_W : DVD_MIN;
  localparam int ITER_W  = $clog2(DVD_W + 1);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_THRESHOLD  = 2'd0,
    CFG_LOCKOUT    = 2'd1,
    CFG_SERIES_GAP = 2'd2
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_SCORE,
    S_SDIV,
    S_WSTART,
    S_WWAIT,
    S_TGO,
    S_TDIV,
    S_OUT
  } seq_state_t;

  // Ring walk status back to the sequencer
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] count;
  } walk_sts_t;

  // Result item, hit in the lowest bit
  typedef struct packed {
    logic [TEMPO_W-1:0]  hit_rate;
    logic [SCORE_W-1:0]  score_best;
    logic [SAMPLE_W-1:0] peak_best;
    logic [SCORE_W-1:0]  score_last;
    logic [SAMPLE_W-1:0] peak_last;
    logic [TIME_W-1:0]   series_best;
    logic [TIME_W-1:0]   series_len;
    logic [TIME_W-1:0]   hit_total;
    logic                hit;
  } result_t;

  localparam int IN_DATA_W  = (((SAMPLE_W + TIME_W) + 7) / 8) * 8;
  localparam int OUT_DATA_W = (($bits(result_t) + 7) / 8) * 8;

endpackage

>>> design/ihc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on ihc_pkg for operand widths.
`timescale 1ns / 1ps

module ihc_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ihc_pkg::DVD_W-1:0] dividend,
  input  logic [ihc_pkg::DIV_W-1:0] divisor,
  output logic                     done,
  output logic [ihc_pkg::DVD_W-1:0] quotient
);
  import ihc_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [ITER_W-1:0] iter_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dvs_r;
  logic [DIV_W:0]    rem_sh;
  logic              fits;

  // Trial subtract of the shifted remainder
  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= ITER_W'(DVD_W);
      end else if (busy_r) begin
        iter_r <= iter_r - 1'b1;
        if (iter_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? DIV_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DIV_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

>>> design/ihc_ring.sv
// Ring of recent hit times with a fill count, and the walk that counts
// entries at or after a given time. Depends on ihc_pkg.
`timescale 1ns / 1ps

module ihc_ring (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clear,
  input  logic                       wr_en,
  input  logic [ihc_pkg::TIME_W-1:0] wr_time,
  input  logic                       walk_start,
  input  logic [ihc_pkg::TIME_W-1:0] since,
  output ihc_pkg::walk_sts_t         sts
);
  import ihc_pkg::*;

  logic [TIME_W-1:0]  mem [HISTORY_DEPTH];
  logic [HIST_AW-1:0] wr_ptr_r;
  logic [CNT_W-1:0]   fill_r;
  logic [CNT_W-1:0]   addr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [TIME_W-1:0]  rd_data_r;
  logic               busy_r;
  logic               issue_r;
  logic               pend_r;
  logic               done_r;
  logic               more;

  assign more = addr_r < fill_r;

  // Write side: pointer and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      fill_r   <= '0;
    end else if (clear) begin
      wr_ptr_r <= '0;
      fill_r   <= '0;
    end else if (wr_en) begin
      wr_ptr_r <= (wr_ptr_r == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (fill_r != CNT_W'(HISTORY_DEPTH)) fill_r <= fill_r + 1'b1;
    end
  end

  // Memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr_r] <= wr_time;
    rd_data_r <= mem[addr_r[HIST_AW-1:0]];
  end

  // Walk: issue one read a cycle, compare the data in the following cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      issue_r <= 1'b0;
      pend_r  <= 1'b0;
      done_r  <= 1'b0;
      addr_r  <= '0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (walk_start) begin
        busy_r  <= 1'b1;
        issue_r <= 1'b1;
        pend_r  <= 1'b0;
        addr_r  <= '0;
        cnt_r   <= '0;
      end else if (busy_r) begin
        pend_r <= issue_r && more;
        if (issue_r) begin
          if (more) addr_r <= addr_r + 1'b1;
          else      issue_r <= 1'b0;
        end
        if (pend_r && (rd_data_r >= since)) cnt_r <= cnt_r + 1'b1;
        if (!issue_r && !pend_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.done  = done_r;
  assign sts.count = cnt_r;

endmodule

>>> design/impact_hit_counter.sv
// Top level of the impact hit counter: configuration registers, session
// metrics, sequencer and output register. Uses ihc_pkg, ihc_div, ihc_ring.
//
// Usage: each input transfer carries one sensor sample and a millisecond time.
// tuser high starts a session: metrics and hit ring are cleared, no result.
// A sample with tlast closes a peak window and yields exactly one result
// transfer; other samples only update the window peak and give no result.
// Samples without tlast, and session starts, are taken without leaving idle.
// A window end runs a sequence on one shared divider: a setup step, the
// score division (only on a hit), a walk over the valid ring entries (one
// entry a cycle), the tempo division and a step to load the output; an
// empty tempo window skips walk and division. in_tready stays low until
// out_tvalid rises. The result sits in an output register; if the receiver
// stalls, the next samples are still taken, and a following window end
// waits until the held result has been transferred. Configuration writes
// are taken in any cycle and must only happen while the block is idle.
// Reset (rst_n low, synchronous) loads the register defaults, clears all
// metrics and the ring fill count, and empties the output register.
`timescale 1ns / 1ps

module impact_hit_counter (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ihc_pkg::IN_DATA_W-1:0]  in_tdata,  // sample[11:0], now_ms[43:12]
  input  logic                           in_tuser,  // start_session
  input  logic                           in_tlast,  // last_in_window
  // Result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // hit[0], hit_total[32:1], series_len[64:33], series_best[96:65],
  // peak_last[108:97], score_last[118:109], peak_best[130:119],
  // score_best[140:131], hit_rate[162:141]
  output logic [ihc_pkg::OUT_DATA_W-1:0] out_tdata,
  // Configuration
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_addr,
  input  logic [ihc_pkg::CFG_W-1:0]      cfg_wdata
);
  import ihc_pkg::*;

  seq_state_t state_r, state_nxt;

  // Configuration
  logic [SAMPLE_W-1:0] thr_r;
  logic [LOCK_W-1:0]   lock_r;
  logic [GAP_W-1:0]    gap_r;

  // Metrics
  logic [SAMPLE_W-1:0] wpeak_r;
  logic [TIME_W-1:0]   hit_cnt_r;
  logic [TIME_W-1:0]   last_hit_r;
  logic [TIME_W-1:0]   lock_end_r;
  logic [TIME_W-1:0]   ser_now_r;
  logic [TIME_W-1:0]   ser_max_r;
  logic [SAMPLE_W-1:0] rpeak_r;
  logic [SCORE_W-1:0]  rscore_r;
  logic [SAMPLE_W-1:0] tpeak_r;
  logic [SCORE_W-1:0]  tscore_r;
  logic [TIME_W-1:0]   sess_r;

  // Per window-end working registers
  logic                hit_r;
  logic [SAMPLE_W-1:0] peak_r;
  logic [TIME_W-1:0]   now_r;
  logic [DVD_W-1:0]    prod_r;
  logic [WIN_W-1:0]    win_r;
  logic [TIME_W-1:0]   since_r;
  logic [TEMPO_W-1:0]  tempo_r;

  // Output register
  logic    out_valid_r;
  result_t res_r;

  // Input fields
  logic [SAMPLE_W-1:0] in_sample;
  logic [TIME_W-1:0]   in_now;
  logic                accept;
  logic [SAMPLE_W-1:0] peak_c;
  logic                hit_c;
  logic [TIME_W-1:0]   gap_c;
  logic [TIME_W-1:0]   elapsed_c;
  logic [SCORE_W-1:0]  score_c;

  // Shared unit and ring hookup
  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [DIV_W-1:0]  div_dvs;
  logic              div_done;
  logic [DVD_W-1:0]  div_q;
  logic              walk_start;
  walk_sts_t         walk_sts;
  logic              ring_wr;
  logic              load_out;

  assign in_sample = in_tdata[SAMPLE_W-1:0];
  assign in_now    = in_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W];
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Window peak including this sample, and the hit decision
  assign peak_c    = (in_sample > wpeak_r) ? in_sample : wpeak_r;
  assign hit_c     = (peak_c > thr_r) && (in_now > lock_end_r);
  assign gap_c     = in_now - last_hit_r;
  assign elapsed_c = now_r - sess_r;
  assign ring_wr   = accept && !in_tuser && in_tlast && hit_c;
  assign score_c   = (div_q > DVD_W'(SCORE_MAX)) ? SCORE_W'(SCORE_MAX) : div_q[SCORE_W-1:0];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THRESHOLD_RST;
      lock_r <= LOCKOUT_RST;
      gap_r  <= GAP_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_THRESHOLD:  thr_r  <= cfg_wdata[SAMPLE_W-1:0];
        CFG_LOCKOUT:    lock_r <= cfg_wdata[LOCK_W-1:0];
        CFG_SERIES_GAP: gap_r  <= cfg_wdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state and unit controls
  always_comb begin
    state_nxt  = state_r;
    div_start  = 1'b0;
    div_dvd    = prod_r;
    div_dvs    = DIV_W'(SAMPLE_W'(FULL_SCALE) - thr_r);
    walk_start = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept && !in_tuser && in_tlast) state_nxt = S_PREP;
      end
      S_PREP:  state_nxt = S_SCORE;
      S_SCORE: begin
        div_start = hit_r;
        state_nxt = hit_r ? S_SDIV : S_WSTART;
      end
      S_SDIV: begin
        if (div_done) state_nxt = S_WSTART;
      end
      S_WSTART: begin
        if (win_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          walk_start = 1'b1;
          state_nxt  = S_WWAIT;
        end
      end
      S_WWAIT: begin
        if (walk_sts.done) state_nxt = S_TGO;
      end
      S_TGO: begin
        div_start = 1'b1;
        div_dvs   = DIV_W'(win_r);
        state_nxt = S_TDIV;
      end
      S_TDIV: begin
        if (div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Session metrics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpeak_r    <= '0;
      hit_cnt_r  <= '0;
      last_hit_r <= '0;
      lock_end_r <= '0;
      ser_now_r  <= '0;
      ser_max_r  <= '0;
      rpeak_r    <= '0;
      rscore_r   <= '0;
      tpeak_r    <= '0;
      tscore_r   <= '0;
      sess_r     <= '0;
    end else begin
      if (accept) begin
        if (in_tuser) begin
          wpeak_r    <= '0;
          hit_cnt_r  <= '0;
          last_hit_r <= '0;
          lock_end_r <= '0;
          ser_now_r  <= '0;
          ser_max_r  <= '0;
          rpeak_r    <= '0;
          rscore_r   <= '0;
          tpeak_r    <= '0;
          tscore_r   <= '0;
          sess_r     <= in_now;
        end else if (!in_tlast) begin
          wpeak_r <= peak_c;
        end else begin
          wpeak_r <= '0;
          if (hit_c) begin
            hit_cnt_r  <= hit_cnt_r + 1'b1;
            ser_now_r  <= (gap_c <= TIME_W'(gap_r)) ? ser_now_r + 1'b1 : TIME_W'(1);
            last_hit_r <= in_now;
            lock_end_r <= in_now + TIME_W'(lock_r);
            rpeak_r    <= peak_c;
            if (peak_c > tpeak_r) tpeak_r <= peak_c;
          end
        end
      end
      // Series record follows the updated series length
      if (state_r == S_PREP && hit_r && ser_now_r > ser_max_r) ser_max_r <= ser_now_r;
      // Score from the shared divider
      if (state_r == S_SDIV && div_done) begin
        rscore_r <= score_c;
        if (score_c > tscore_r) tscore_r <= score_c;
      end
    end
  end

  // Working registers of one window end
  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r  <= hit_c;
      peak_r <= peak_c;
      now_r  <= in_now;
    end
    if (state_r == S_PREP) begin
      prod_r <= DVD_W'(peak_r - thr_r) * DVD_W'(SCORE_MAX);
      win_r  <= (elapsed_c < TIME_W'(TEMPO_WINDOW_MS)) ? elapsed_c[WIN_W-1:0]
                                                      : WIN_W'(TEMPO_WINDOW_MS);
    end
    if (state_r == S_SCORE) since_r <= now_r - TIME_W'(win_r);
    if (state_r == S_WSTART) tempo_r <= '0;
    if (state_r == S_WWAIT && walk_sts.done)
      prod_r <= DVD_W'(walk_sts.count) * DVD_W'(HPM_SCALE);
    if (state_r == S_TDIV && div_done)
      tempo_r <= (div_q > DVD_W'(TEMPO_LIMIT)) ? TEMPO_W'(TEMPO_LIMIT) : div_q[TEMPO_W-1:0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_r.hit         <= hit_r;
      res_r.hit_total   <= hit_cnt_r;
      res_r.series_len  <= ser_now_r;
      res_r.series_best <= ser_max_r;
      res_r.peak_last   <= rpeak_r;
      res_r.score_last  <= rscore_r;
      res_r.peak_best   <= tpeak_r;
      res_r.score_best  <= tscore_r;
      res_r.hit_rate    <= tempo_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, res_r};

  // Shared divider
  ihc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // Hit time ring
  ihc_ring u_ring (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (accept && in_tuser),
    .wr_en      (ring_wr),
    .wr_time    (in_now),
    .walk_start (walk_start),
    .since      (since_r),
    .sts        (walk_sts)
  );

endmodule
